// ===== rtl/tcsm_pkg.sv =====
package tcsm_pkg;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_SEGMENT = 2'd0;
    localparam logic [1:0] OP_CONNECT = 2'd1;
    localparam logic [1:0] OP_LISTEN  = 2'd2;
    localparam logic [1:0] OP_CLOSE   = 2'd3;

    // TCP flag bits.
    localparam logic [7:0] F_FIN = 8'h01;
    localparam logic [7:0] F_SYN = 8'h02;
    localparam logic [7:0] F_RST = 8'h04;
    localparam logic [7:0] F_ACK = 8'h10;

    localparam logic [31:0] INITIAL_SEQ = 32'h1234_5678;

    // Externally visible state codes.
    localparam logic [3:0] CODE_CLOSED      = 4'd0;
    localparam logic [3:0] CODE_LISTEN      = 4'd1;
    localparam logic [3:0] CODE_SYN_SENT    = 4'd2;
    localparam logic [3:0] CODE_SYN_RCVD    = 4'd3;
    localparam logic [3:0] CODE_ESTABLISHED = 4'd4;
    localparam logic [3:0] CODE_FIN_WAIT_1  = 4'd5;
    localparam logic [3:0] CODE_FIN_ACKED   = 4'd6;
    localparam logic [3:0] CODE_TIME_WAIT   = 4'd7;
    localparam logic [3:0] CODE_PEER_CLOSED = 4'd8;
    localparam logic [3:0] CODE_CLOSING     = 4'd9;
    localparam logic [3:0] CODE_LAST_ACK    = 4'd10;

    // Event queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        EV_IGNORE  = 3'd0,
        EV_SEGMENT = 3'd1,
        EV_CONNECT = 3'd2,
        EV_LISTEN  = 3'd3,
        EV_CLOSE   = 3'd4
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
    } event_t;

endpackage

// ===== rtl/tcp_connection_state_machine_top.sv =====
// With the queue empty, an accepted input transaction is written into the event queue and,
// once the back end pops it, its result is registered in the output register.
// Throughput: one event per cycle while out_ready holds; the back end's state update sets the rate.
// A two-entry event queue lets the input and output sides stall independently.
// Reset: connection CLOSED, local sequence 0x12345678, remote ack 0, local port 0,
// queue and output register empty.
module tcp_connection_state_machine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  seg_flags,
    input  logic [15:0] seg_dest_port,
    input  logic [31:0] seg_seq,
    input  logic [31:0] seg_ack,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic [7:0]  send_flags,
    output logic [31:0] send_seq,
    output logic [31:0] send_ack,
    output logic [3:0]  new_state,
    output logic        done_res
);
    import tcsm_pkg::*;

    logic    q_full;
    logic    q_push;
    event_t  front_ev;
    event_t  head_ev;
    logic    head_valid;
    logic    pop;

    tcsm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .seg_flags     (seg_flags),
        .seg_dest_port (seg_dest_port),
        .seg_seq       (seg_seq),
        .seg_ack       (seg_ack),
        .q_full        (q_full),
        .q_push        (q_push),
        .ev            (front_ev)
    );

    tcsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ev    (front_ev),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ev    (head_ev)
    );

    tcsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .send_valid (send_valid),
        .send_flags (send_flags),
        .send_seq   (send_seq),
        .send_ack   (send_ack),
        .new_state  (new_state),
        .done_res   (done_res)
    );

endmodule

// ===== rtl/tcsm_front.sv =====
module tcsm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       operation,
    input  logic [7:0]       seg_flags,
    input  logic [15:0]      seg_dest_port,
    input  logic [31:0]      seg_seq,
    input  logic [31:0]      seg_ack,
    input  logic             q_full,
    output logic             q_push,
    output tcsm_pkg::event_t ev
);
    import tcsm_pkg::*;

    logic [15:0] local_port_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_port_reg <= '0;
        end
        else if (cfg_valid)
        begin
            local_port_reg <= cfg_data;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Segments for another port are resolved here and pass on as no-ops.
    always_comb
    begin
        ev.flags = seg_flags;
        ev.seq   = seg_seq;
        ev.ack   = seg_ack;
        case (operation)
            OP_SEGMENT: ev.kind = (seg_dest_port == local_port_reg) ? EV_SEGMENT : EV_IGNORE;
            OP_CONNECT: ev.kind = EV_CONNECT;
            OP_LISTEN:  ev.kind = EV_LISTEN;
            OP_CLOSE:   ev.kind = EV_CLOSE;
            default:    ev.kind = EV_CLOSE;
        endcase
    end

endmodule

// ===== rtl/tcsm_queue.sv =====
module tcsm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcsm_pkg::event_t  push_ev,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tcsm_pkg::event_t  head_ev
);
    import tcsm_pkg::*;

    event_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_ev    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_ev;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

// ===== rtl/tcsm_back.sv =====
module tcsm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  tcsm_pkg::event_t head_ev,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             send_valid,
    output logic [7:0]       send_flags,
    output logic [31:0]      send_seq,
    output logic [31:0]      send_ack,
    output logic [3:0]       new_state,
    output logic             done_res
);
    import tcsm_pkg::*;

    typedef enum logic [10:0] {
        ST_CLOSED      = 11'b000_0000_0001,
        ST_LISTEN      = 11'b000_0000_0010,
        ST_SYN_SENT    = 11'b000_0000_0100,
        ST_SYN_RCVD    = 11'b000_0000_1000,
        ST_ESTABLISHED = 11'b000_0001_0000,
        ST_FIN_WAIT_1  = 11'b000_0010_0000,
        ST_FIN_ACKED   = 11'b000_0100_0000,
        ST_TIME_WAIT   = 11'b000_1000_0000,
        ST_PEER_CLOSED = 11'b001_0000_0000,
        ST_CLOSING     = 11'b010_0000_0000,
        ST_LAST_ACK    = 11'b100_0000_0000
    } conn_state_t;

    function automatic logic [3:0] state_code(conn_state_t st);
        case (st)
            ST_CLOSED:      return CODE_CLOSED;
            ST_LISTEN:      return CODE_LISTEN;
            ST_SYN_SENT:    return CODE_SYN_SENT;
            ST_SYN_RCVD:    return CODE_SYN_RCVD;
            ST_ESTABLISHED: return CODE_ESTABLISHED;
            ST_FIN_WAIT_1:  return CODE_FIN_WAIT_1;
            ST_FIN_ACKED:   return CODE_FIN_ACKED;
            ST_TIME_WAIT:   return CODE_TIME_WAIT;
            ST_PEER_CLOSED: return CODE_PEER_CLOSED;
            ST_CLOSING:     return CODE_CLOSING;
            ST_LAST_ACK:    return CODE_LAST_ACK;
            default:        return CODE_CLOSED;
        endcase
    endfunction

    conn_state_t state_reg, state_next;
    logic [31:0] local_seq_reg, local_seq_next;
    logic [31:0] remote_ack_reg, remote_ack_next;

    logic        out_valid_reg;
    logic        send_valid_reg, send_valid_next;
    logic [7:0]  send_flags_reg, send_flags_next;
    logic [31:0] send_seq_reg, send_seq_next;
    logic [31:0] send_ack_reg, send_ack_next;
    logic [3:0]  new_state_reg, new_state_next;
    logic        done_reg, done_next;

    logic        tx;
    logic [7:0]  tx_flags;

    // The output register is refilled in the same cycle that it is taken.
    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        local_seq_next  = local_seq_reg;
        remote_ack_next = remote_ack_reg;
        tx              = 1'b0;
        tx_flags        = '0;
        done_next       = 1'b1;
        case (head_ev.kind)
            EV_IGNORE:
            begin
                done_next = 1'b1;
            end
            EV_CONNECT:
            begin
                tx         = 1'b1;
                tx_flags   = F_SYN;
                state_next = ST_SYN_SENT;
                done_next  = 1'b0;
            end
            EV_LISTEN:
            begin
                state_next = ST_LISTEN;
                done_next  = 1'b0;
            end
            EV_CLOSE:
            begin
                case (state_reg)
                    ST_SYN_RCVD, ST_ESTABLISHED:
                    begin
                        tx         = 1'b1;
                        tx_flags   = F_FIN;
                        state_next = ST_FIN_WAIT_1;
                        done_next  = 1'b0;
                    end
                    ST_PEER_CLOSED:
                    begin
                        tx         = 1'b1;
                        tx_flags   = F_FIN;
                        state_next = ST_LAST_ACK;
                        done_next  = 1'b0;
                    end
                    ST_FIN_WAIT_1, ST_FIN_ACKED, ST_CLOSING, ST_LAST_ACK:
                    begin
                        done_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_CLOSED;
                        done_next  = 1'b1;
                    end
                endcase
            end
            EV_SEGMENT:
            begin
                case (state_reg)
                    ST_CLOSED:
                    begin
                        tx        = 1'b1;
                        tx_flags  = F_RST | F_ACK;
                        done_next = 1'b1;
                    end
                    ST_LISTEN:
                    begin
                        if ((head_ev.flags & F_SYN) != '0)
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_SYN | F_ACK;
                            state_next = ST_SYN_RCVD;
                        end
                        done_next = 1'b0;
                    end
                    ST_SYN_SENT:
                    begin
                        done_next = 1'b0;
                        if (head_ev.flags == (F_SYN | F_ACK))
                        begin
                            local_seq_next  = head_ev.ack;
                            remote_ack_next = head_ev.seq + 32'd1;
                            tx              = 1'b1;
                            tx_flags        = F_ACK;
                            state_next      = ST_ESTABLISHED;
                            done_next       = 1'b1;
                        end
                        else if (head_ev.flags == F_SYN)
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_SYN | F_ACK;
                            state_next = ST_SYN_RCVD;
                        end
                        else if (head_ev.flags == (F_RST | F_ACK))
                        begin
                            state_next = ST_CLOSED;
                        end
                        else
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_RST;
                            state_next = ST_CLOSED;
                        end
                    end
                    ST_SYN_RCVD:
                    begin
                        if ((head_ev.flags & F_ACK) != '0)
                        begin
                            state_next = ST_ESTABLISHED;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            done_next = 1'b0;
                        end
                    end
                    ST_ESTABLISHED:
                    begin
                        tx       = 1'b1;
                        tx_flags = F_ACK;
                        if (head_ev.flags == F_FIN)
                        begin
                            state_next = ST_PEER_CLOSED;
                            done_next  = 1'b0;
                        end
                    end
                    ST_FIN_WAIT_1:
                    begin
                        done_next = 1'b0;
                        if (head_ev.flags == (F_FIN | F_ACK))
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_ACK;
                            state_next = ST_TIME_WAIT;
                        end
                        else if (head_ev.flags == F_FIN)
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_ACK;
                            state_next = ST_CLOSING;
                        end
                        else if (head_ev.flags == F_ACK)
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_ACK;
                            state_next = ST_FIN_ACKED;
                        end
                    end
                    ST_FIN_ACKED:
                    begin
                        done_next = 1'b0;
                        if ((head_ev.flags & F_FIN) != '0)
                        begin
                            tx         = 1'b1;
                            tx_flags   = F_ACK;
                            state_next = ST_TIME_WAIT;
                        end
                    end
                    ST_PEER_CLOSED:
                    begin
                        state_next = ST_LAST_ACK;
                        done_next  = 1'b0;
                    end
                    ST_CLOSING:
                    begin
                        done_next = 1'b0;
                        if (head_ev.flags == F_ACK)
                        begin
                            state_next = ST_TIME_WAIT;
                        end
                    end
                    ST_TIME_WAIT:
                    begin
                        state_next = ST_CLOSED;
                        done_next  = 1'b1;
                    end
                    ST_LAST_ACK:
                    begin
                        if (head_ev.flags == F_ACK)
                        begin
                            state_next = ST_CLOSED;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            done_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b1;
            end
        endcase

        // A transmitted segment carries the numbers as they stand after the event.
        send_valid_next = tx;
        send_flags_next = tx ? tx_flags : '0;
        send_seq_next   = tx ? local_seq_next : '0;
        send_ack_next   = tx ? remote_ack_next : '0;
        new_state_next  = state_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLOSED;
            local_seq_reg  <= INITIAL_SEQ;
            remote_ack_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg      <= state_next;
                local_seq_reg  <= local_seq_next;
                remote_ack_reg <= remote_ack_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            send_valid_reg <= send_valid_next;
            send_flags_reg <= send_flags_next;
            send_seq_reg   <= send_seq_next;
            send_ack_reg   <= send_ack_next;
            new_state_reg  <= new_state_next;
            done_reg       <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign send_valid = send_valid_reg;
    assign send_flags = send_flags_reg;
    assign send_seq   = send_seq_reg;
    assign send_ack   = send_ack_reg;
    assign new_state  = new_state_reg;
    assign done_res   = done_reg;

    a_ignore_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_ev.kind == EV_IGNORE) |=>
            (out_valid_reg && !send_valid_reg && done_reg
             && new_state_reg == $past(state_code(state_reg))))
        else $error("ignored segment changed state or sent a segment");

    a_connect_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_ev.kind == EV_CONNECT) |=>
            (send_valid_reg && send_flags_reg == F_SYN && new_state_reg == CODE_SYN_SENT))
        else $error("connect did not send SYN");

    a_quiet_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !send_valid_reg) |->
            (send_flags_reg == '0 && send_seq_reg == '0 && send_ack_reg == '0))
        else $error("segment fields set without a segment to send");

endmodule
